// ----- rtl/i2cm_pkg.sv -----
// I2C master bit engine: shared types and constants.
// No dependencies; used by i2cm_step and i2c_master_bit_engine_core.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned DELAY_TICKS_W     = 16;
  localparam logic [15:0] DELAY_TICKS_RESET = 16'd250;
  localparam int unsigned APB_ADDR_W        = 3;
  localparam int unsigned APB_DATA_W        = 32;
  localparam int unsigned MSB_BIT           = 7;

  // register index (paddr[2])
  localparam logic REG_DELAY_TICKS = 1'b0;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_ACK   = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_CHK = 4'd1,
    PH_START_LOW = 4'd2,
    PH_STOP_WAIT = 4'd3,
    PH_STOP_END  = 4'd4,
    PH_WR_HIGH   = 4'd5,
    PH_WR_LOW    = 4'd6,
    PH_WA_HIGH   = 4'd7,
    PH_WA_SAMPLE = 4'd8,
    PH_WA_END    = 4'd9,
    PH_RD_HIGH   = 4'd10,
    PH_RD_SAMPLE = 4'd11,
    PH_AK_HIGH   = 4'd12,
    PH_AK_LOW    = 4'd13,
    PH_AK_END    = 4'd14
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] wr_data;
    logic       ack_level;
    logic       sda_in;
    logic       scl_in;
  } item_t;

  typedef struct packed {
    logic       sda_drive;
    logic       scl_drive;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       nack;
    logic       start_error;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_master_bit_engine_core.sv -----
// I2C master bit engine top: request input register, step engine, result register, APB regs.
// Depends on i2cm_pkg and i2cm_step.
//
//  channel   handshake               payload
//  request   in_valid / in_ready     cmd_valid opcode wr_data ack_level sda_in scl_in
//  result    out_valid / out_ready   sda_drive scl_drive ready_res done_res rd_data nack start_error
//  config    APB psel/penable/pready paddr pwdata prdata (delay_ticks at 0x0)
//
// One request per cycle while results are taken; a request passes through the input register, then the result register.
// Each request is one bus tick: the step engine evaluates it from the input register
// into the result register. A stalled result holds the step; the input register still
// takes one more request. rst is synchronous and clears engine state, delay_ticks to 250.
`default_nettype none

module i2c_master_bit_engine_core #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  cmd_valid,
  input  wire [2:0]                            opcode,
  input  wire [7:0]                            wr_data,
  input  wire                                  ack_level,
  input  wire                                  sda_in,
  input  wire                                  scl_in,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 sda_drive,
  output logic                                 scl_drive,
  output logic                                 ready_res,
  output logic                                 done_res,
  output logic [7:0]                           rd_data,
  output logic                                 nack,
  output logic                                 start_error,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [i2cm_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire [i2cm_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [i2cm_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  logic [i2cm_pkg::DELAY_TICKS_W-1:0] delay_ticks;
  i2cm_pkg::item_t   in_q;
  logic              in_q_valid;
  logic              advance;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t out_q;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= i2cm_pkg::DELAY_TICKS_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == i2cm_pkg::REG_DELAY_TICKS) begin
      delay_ticks <= pwdata[i2cm_pkg::DELAY_TICKS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == i2cm_pkg::REG_DELAY_TICKS) begin
      prdata = i2cm_pkg::APB_DATA_W'(delay_ticks);
    end
  end

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= '{cmd_valid: cmd_valid, opcode: opcode, wr_data: wr_data,
                ack_level: ack_level, sda_in: sda_in, scl_in: scl_in};
    end
  end

  i2cm_step #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .delay_ticks (delay_ticks),
    .step_en     (advance),
    .item        (in_q),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign sda_drive   = out_q.sda_drive;
  assign scl_drive   = out_q.scl_drive;
  assign ready_res   = out_q.ready_res;
  assign done_res    = out_q.done_res;
  assign rd_data     = out_q.rd_data;
  assign nack        = out_q.nack;
  assign start_error = out_q.start_error;

  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> ready_res)
    else $error("done reported while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_q))
    else $error("stalled result lost or changed");

  a_in_q_hold: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q))
    else $error("pending request dropped");

endmodule

`default_nettype wire

// ----- rtl/i2cm_step.sv -----
// I2C master bit engine: phase state machine, advanced by one step per accepted request.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_step #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire logic [i2cm_pkg::DELAY_TICKS_W-1:0] delay_ticks,
  input  wire                                   step_en,
  input  wire i2cm_pkg::item_t                  item,
  output i2cm_pkg::result_t                     res
);

  i2cm_pkg::phase_t phase, phase_next;
  logic [2:0]             bit_count, bit_count_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next;
  logic                   sda_level, sda_level_next;
  logic                   scl_level, scl_level_next;
  logic                   nack, nack_next;
  logic                   start_error, start_error_next;
  logic [7:0]             rd_hold, rd_hold_next;
  logic                   done;

  logic [i2cm_pkg::DELAY_TICKS_W-1:0] delay_m1;
  logic [DELAY_WIDTH-1:0]             delay_load;

  // zero acts as one
  assign delay_m1 = (delay_ticks == '0) ? '0 : delay_ticks - 1'b1;

  generate
    if (DELAY_WIDTH >= i2cm_pkg::DELAY_TICKS_W) begin : g_wide
      assign delay_load = DELAY_WIDTH'(delay_m1);
    end else begin : g_sat
      assign delay_load = ((delay_m1 >> DELAY_WIDTH) != '0) ? '1 : delay_m1[DELAY_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= i2cm_pkg::PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      delay_count <= '0;
      sda_level   <= 1'b1;
      scl_level   <= 1'b1;
      nack        <= 1'b0;
      start_error <= 1'b0;
      rd_hold     <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      sda_level   <= sda_level_next;
      scl_level   <= scl_level_next;
      nack        <= nack_next;
      start_error <= start_error_next;
      rd_hold     <= rd_hold_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    sda_level_next   = sda_level;
    scl_level_next   = scl_level;
    nack_next        = nack;
    start_error_next = start_error;
    rd_hold_next     = rd_hold;
    done             = 1'b0;

    if (phase == i2cm_pkg::PH_IDLE) begin
      if (item.cmd_valid) begin
        case (item.opcode)
          i2cm_pkg::OP_START: begin
            sda_level_next   = 1'b1;
            scl_level_next   = 1'b1;
            delay_count_next = delay_load;
            phase_next       = i2cm_pkg::PH_START_CHK;
          end
          i2cm_pkg::OP_STOP: begin
            sda_level_next   = 1'b0;
            scl_level_next   = 1'b1;
            delay_count_next = delay_load;
            phase_next       = i2cm_pkg::PH_STOP_WAIT;
          end
          i2cm_pkg::OP_WRITE: begin
            shift_reg_next   = item.wr_data;
            bit_count_next   = '0;
            sda_level_next   = item.wr_data[i2cm_pkg::MSB_BIT];
            delay_count_next = delay_load;
            phase_next       = i2cm_pkg::PH_WR_HIGH;
          end
          i2cm_pkg::OP_READ: begin
            shift_reg_next   = '0;
            bit_count_next   = '0;
            sda_level_next   = 1'b1;
            scl_level_next   = 1'b0;
            delay_count_next = delay_load;
            phase_next       = i2cm_pkg::PH_RD_HIGH;
          end
          i2cm_pkg::OP_ACK: begin
            scl_level_next   = 1'b0;
            sda_level_next   = item.ack_level;
            delay_count_next = delay_load;
            phase_next       = i2cm_pkg::PH_AK_HIGH;
          end
          default: begin
          end
        endcase
      end
    end else if (delay_count != '0) begin
      delay_count_next = delay_count - 1'b1;
    end else begin
      case (phase)
        i2cm_pkg::PH_START_CHK: begin
          if (!item.sda_in) begin
            start_error_next = 1'b1;
            done             = 1'b1;
            phase_next       = i2cm_pkg::PH_IDLE;
          end else begin
            start_error_next = 1'b0;
            sda_level_next   = 1'b0;
            delay_count_next = delay_load;
            phase_next       = i2cm_pkg::PH_START_LOW;
          end
        end
        i2cm_pkg::PH_START_LOW: begin
          scl_level_next = 1'b0;
          done           = 1'b1;
          phase_next     = i2cm_pkg::PH_IDLE;
        end
        i2cm_pkg::PH_STOP_WAIT: begin
          if (item.scl_in) begin
            sda_level_next   = 1'b1;
            delay_count_next = delay_load;
            phase_next       = i2cm_pkg::PH_STOP_END;
          end
        end
        i2cm_pkg::PH_STOP_END, i2cm_pkg::PH_WA_END: begin
          done       = 1'b1;
          phase_next = i2cm_pkg::PH_IDLE;
        end
        i2cm_pkg::PH_WR_HIGH: begin
          scl_level_next   = 1'b1;
          delay_count_next = delay_load;
          phase_next       = i2cm_pkg::PH_WR_LOW;
        end
        i2cm_pkg::PH_WR_LOW: begin
          shift_reg_next   = {shift_reg[6:0], 1'b0};
          scl_level_next   = 1'b0;
          delay_count_next = delay_load;
          if (bit_count == 3'd7) begin
            bit_count_next = '0;
            sda_level_next = 1'b1;
            phase_next     = i2cm_pkg::PH_WA_HIGH;
          end else begin
            bit_count_next = bit_count + 1'b1;
            sda_level_next = shift_reg[i2cm_pkg::MSB_BIT-1];
            phase_next     = i2cm_pkg::PH_WR_HIGH;
          end
        end
        i2cm_pkg::PH_WA_HIGH: begin
          scl_level_next   = 1'b1;
          delay_count_next = delay_load;
          phase_next       = i2cm_pkg::PH_WA_SAMPLE;
        end
        i2cm_pkg::PH_WA_SAMPLE: begin
          nack_next        = item.sda_in;
          scl_level_next   = 1'b0;
          delay_count_next = delay_load;
          phase_next       = i2cm_pkg::PH_WA_END;
        end
        i2cm_pkg::PH_RD_HIGH: begin
          scl_level_next   = 1'b1;
          delay_count_next = delay_load;
          phase_next       = i2cm_pkg::PH_RD_SAMPLE;
        end
        i2cm_pkg::PH_RD_SAMPLE: begin
          shift_reg_next = {shift_reg[6:0], item.sda_in};
          scl_level_next = 1'b0;
          if (bit_count == 3'd7) begin
            bit_count_next = '0;
            rd_hold_next   = {shift_reg[6:0], item.sda_in};
            done           = 1'b1;
            phase_next     = i2cm_pkg::PH_IDLE;
          end else begin
            bit_count_next   = bit_count + 1'b1;
            delay_count_next = delay_load;
            phase_next       = i2cm_pkg::PH_RD_HIGH;
          end
        end
        i2cm_pkg::PH_AK_HIGH: begin
          scl_level_next   = 1'b1;
          delay_count_next = delay_load;
          phase_next       = i2cm_pkg::PH_AK_LOW;
        end
        i2cm_pkg::PH_AK_LOW: begin
          scl_level_next   = 1'b0;
          delay_count_next = delay_load;
          phase_next       = i2cm_pkg::PH_AK_END;
        end
        i2cm_pkg::PH_AK_END: begin
          sda_level_next = 1'b1;
          done           = 1'b1;
          phase_next     = i2cm_pkg::PH_IDLE;
        end
        default: begin
          phase_next = i2cm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.sda_drive   = sda_level_next;
    res.scl_drive   = scl_level_next;
    res.ready_res   = (phase_next == i2cm_pkg::PH_IDLE);
    res.done_res    = done;
    res.rd_data     = rd_hold_next;
    res.nack        = nack_next;
    res.start_error = start_error_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && done |=> phase == i2cm_pkg::PH_IDLE)
    else $error("done without return to idle");

  a_delay_hold: assert property (@(posedge clk) disable iff (rst)
    step_en && phase != i2cm_pkg::PH_IDLE && delay_count != '0
    |=> phase == $past(phase) && delay_count == $past(delay_count) - 1'b1)
    else $error("phase moved during delay");

  a_idle_no_cmd: assert property (@(posedge clk) disable iff (rst)
    step_en && phase == i2cm_pkg::PH_IDLE && !item.cmd_valid
    |=> phase == i2cm_pkg::PH_IDLE && $stable(scl_level) && $stable(sda_level))
    else $error("idle engine moved without a command");

  a_bitcnt_phase: assert property (@(posedge clk) disable iff (rst)
    bit_count != '0 |-> phase == i2cm_pkg::PH_WR_HIGH || phase == i2cm_pkg::PH_WR_LOW
      || phase == i2cm_pkg::PH_RD_HIGH || phase == i2cm_pkg::PH_RD_SAMPLE)
    else $error("bit count live outside a byte transfer");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for i2c_master_bit_engine_core: bus ticks are streamed in, every result is
// checked against an in-bench model of the engine, with delay settings changed over APB.
// Depends on i2cm_pkg and the RTL of i2c_master_bit_engine_core.
`timescale 1ns / 1ps

module tb;
  import i2cm_pkg::*;

  localparam int LVL_LOW  = 0;
  localparam int LVL_HIGH = 1;
  localparam int LVL_RAND = 2;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  item_t req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic sda_drive, scl_drive, ready_res, done_res, nack, start_error;
  logic [7:0] rd_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  i2c_master_bit_engine_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd_valid(req.cmd_valid), .opcode(req.opcode), .wr_data(req.wr_data),
    .ack_level(req.ack_level), .sda_in(req.sda_in), .scl_in(req.scl_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .sda_drive(sda_drive), .scl_drive(scl_drive), .ready_res(ready_res),
    .done_res(done_res), .rd_data(rd_data), .nack(nack), .start_error(start_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // engine model state
  phase_t      eng_phase;
  logic [2:0]  eng_bits;
  logic [7:0]  eng_shift;
  logic [15:0] eng_wait;
  logic        eng_sda, eng_scl;
  logic [1:0]  eng_status;  // [0] nack, [1] start error
  logic [7:0]  eng_rd;
  logic [15:0] cfg_delay = DELAY_TICKS_RESET;

  item_t   tick_queue[$];
  result_t expected_lines[$];
  int issued = 0;
  int taken = 0;
  int errors = 0;
  int idle_left = 0;
  int stall_left = 0;
  int cycles = 0;
  bit steady = 1'b0;

  task automatic hop(input phase_t nxt);
    eng_wait = (cfg_delay == 16'd0) ? 16'd0 : cfg_delay - 16'd1;
    eng_phase = nxt;
  endtask

  task automatic bus_tick(input item_t r, output result_t res);
    logic done;
    done = 1'b0;
    if (eng_phase == PH_IDLE) begin
      if (r.cmd_valid) begin
        case (r.opcode)
          OP_START: begin
            eng_sda = 1'b1; eng_scl = 1'b1;
            hop(PH_START_CHK);
          end
          OP_STOP: begin
            eng_sda = 1'b0; eng_scl = 1'b1;
            hop(PH_STOP_WAIT);
          end
          OP_WRITE: begin
            eng_shift = r.wr_data; eng_bits = 3'd0;
            eng_sda = eng_shift[MSB_BIT];
            hop(PH_WR_HIGH);
          end
          OP_READ: begin
            eng_shift = 8'd0; eng_bits = 3'd0;
            eng_sda = 1'b1; eng_scl = 1'b0;
            hop(PH_RD_HIGH);
          end
          OP_ACK: begin
            eng_scl = 1'b0; eng_sda = r.ack_level;
            hop(PH_AK_HIGH);
          end
          default: ;
        endcase
      end
    end else if (eng_wait != 16'd0) begin
      eng_wait = eng_wait - 16'd1;
    end else begin
      case (eng_phase)
        PH_START_CHK: begin
          if (!r.sda_in) begin
            eng_status[1] = 1'b1;
            done = 1'b1; eng_phase = PH_IDLE;
          end else begin
            eng_status[1] = 1'b0;
            eng_sda = 1'b0;
            hop(PH_START_LOW);
          end
        end
        PH_START_LOW: begin
          eng_scl = 1'b0;
          done = 1'b1; eng_phase = PH_IDLE;
        end
        PH_STOP_WAIT: begin
          if (r.scl_in) begin
            eng_sda = 1'b1;
            hop(PH_STOP_END);
          end
        end
        PH_STOP_END, PH_WA_END: begin
          done = 1'b1; eng_phase = PH_IDLE;
        end
        PH_WR_HIGH: begin
          eng_scl = 1'b1;
          hop(PH_WR_LOW);
        end
        PH_WR_LOW: begin
          eng_shift = eng_shift << 1;
          eng_scl = 1'b0;
          if (eng_bits == 3'd7) begin
            eng_bits = 3'd0;
            eng_sda = 1'b1;
            hop(PH_WA_HIGH);
          end else begin
            eng_bits = eng_bits + 3'd1;
            eng_sda = eng_shift[MSB_BIT];
            hop(PH_WR_HIGH);
          end
        end
        PH_WA_HIGH: begin
          eng_scl = 1'b1;
          hop(PH_WA_SAMPLE);
        end
        PH_WA_SAMPLE: begin
          eng_status[0] = r.sda_in;
          eng_scl = 1'b0;
          hop(PH_WA_END);
        end
        PH_RD_HIGH: begin
          eng_scl = 1'b1;
          hop(PH_RD_SAMPLE);
        end
        PH_RD_SAMPLE: begin
          eng_shift = {eng_shift[6:0], r.sda_in};
          eng_scl = 1'b0;
          if (eng_bits == 3'd7) begin
            eng_bits = 3'd0;
            eng_rd = eng_shift;
            done = 1'b1; eng_phase = PH_IDLE;
          end else begin
            eng_bits = eng_bits + 3'd1;
            hop(PH_RD_HIGH);
          end
        end
        PH_AK_HIGH: begin
          eng_scl = 1'b1;
          hop(PH_AK_LOW);
        end
        PH_AK_LOW: begin
          eng_scl = 1'b0;
          hop(PH_AK_END);
        end
        PH_AK_END: begin
          eng_sda = 1'b1;
          done = 1'b1; eng_phase = PH_IDLE;
        end
        default: eng_phase = PH_IDLE;
      endcase
    end
    res = {eng_sda, eng_scl, eng_phase == PH_IDLE, done, eng_rd, eng_status[0],
           eng_status[1]};
  endtask

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic pick_level(input int sel);
    if (sel == LVL_RAND) return logic'($urandom_range(0, 1));
    return sel == LVL_HIGH;
  endfunction

  function automatic item_t tick_item(input logic cmd, input logic [2:0] op,
                                      input logic [7:0] data, input logic ack,
                                      input int sda_sel, input int scl_sel);
    item_t it;
    it.cmd_valid = cmd;
    it.opcode = op;
    it.wr_data = data;
    it.ack_level = ack;
    it.sda_in = pick_level(sda_sel);
    it.scl_in = pick_level(scl_sel);
    return it;
  endfunction

  task automatic note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : drive
    result_t want;
    if (rst) begin
      in_valid <= 1'b0;
      idle_left <= 0;
      eng_phase = PH_IDLE;
      eng_bits = 3'd0;
      eng_shift = 8'd0;
      eng_wait = 16'd0;
      eng_sda = 1'b1;
      eng_scl = 1'b1;
      eng_status = 2'b00;
      eng_rd = 8'd0;
    end else begin
      if (in_valid && in_ready) begin
        bus_tick(req, want);
        expected_lines.push_back(want);
        taken++;
      end
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          in_valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          req <= tick_queue.pop_front();
          in_valid <= 1'b1;
          idle_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    result_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {sda_drive, scl_drive, ready_res, done_res, rd_data, nack, start_error};
        if (expected_lines.size() == 0) begin
          note_fail("result arrived with no request outstanding");
        end else begin
          want = expected_lines.pop_front();
          if (got !== want)
            note_fail($sformatf({"mismatch: expected sda=%b scl=%b rdy=%b done=%b rd=%h ",
              "nack=%b serr=%b, got sda=%b scl=%b rdy=%b done=%b rd=%h nack=%b serr=%b"},
              want.sda_drive, want.scl_drive, want.ready_res, want.done_res,
              want.rd_data, want.nack, want.start_error,
              got.sda_drive, got.scl_drive, got.ready_res, got.done_res,
              got.rd_data, got.nack, got.start_error));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** i2c_master_bit_engine_core: FAILED **");
      $finish;
    end
  end

  task automatic queue_req(input item_t it);
    tick_queue.push_back(it);
    issued++;
  endtask

  task automatic wait_drain();
    while (!(taken == issued && expected_lines.size() == 0)) @(posedge clk);
  endtask

  // feed quiet ticks until the engine model is back in idle
  task automatic settle(input int sda_sel, input int scl_sel);
    wait_drain();
    while (eng_phase != PH_IDLE) begin
      repeat (int'(cfg_delay) + 16)
        queue_req(tick_item(1'b0, 3'($urandom), 8'($urandom), 1'($urandom),
                            sda_sel, scl_sel));
      wait_drain();
    end
  endtask

  task automatic run_cmd(input opcode_t op, input logic [7:0] data, input logic ack,
                         input int sda_sel, input int scl_sel);
    queue_req(tick_item(1'b1, op, data, ack, sda_sel, scl_sel));
    settle(sda_sel, scl_sel);
  endtask

  task automatic set_delay(input logic [15:0] v);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_DELAY_TICKS, 2'b00};
    pwdata <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_delay = v;
  endtask

  task automatic random_ticks(input int n);
    logic [2:0] op;
    repeat (n) begin
      op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(int'(OP_ACK) + 1, 7))
                                      : 3'($urandom_range(0, int'(OP_ACK)));
      queue_req(tick_item($urandom_range(0, 3) == 0, op, 8'($urandom), 1'($urandom),
                          LVL_RAND, ($urandom_range(0, 9) != 0) ? LVL_HIGH : LVL_LOW));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    run_cmd(OP_START, 8'h00, 1'b0, LVL_HIGH, LVL_HIGH);

    set_delay(16'd0);
    run_cmd(OP_START, 8'h00, 1'b0, LVL_LOW, LVL_HIGH);
    run_cmd(OP_START, 8'h00, 1'b0, LVL_HIGH, LVL_HIGH);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, LVL_HIGH, LVL_HIGH);
    run_cmd(OP_WRITE, 8'h00, 1'b1, LVL_LOW, LVL_HIGH);
    run_cmd(OP_READ, 8'h00, 1'b0, LVL_HIGH, LVL_HIGH);
    run_cmd(OP_READ, 8'hFF, 1'b1, LVL_LOW, LVL_HIGH);
    run_cmd(OP_ACK, 8'h00, 1'b0, LVL_RAND, LVL_HIGH);
    run_cmd(OP_ACK, 8'h00, 1'b1, LVL_RAND, LVL_HIGH);
    // stop held off by a stretched clock
    queue_req(tick_item(1'b1, OP_STOP, 8'h00, 1'b0, LVL_RAND, LVL_LOW));
    repeat (20) queue_req(tick_item(1'b0, OP_STOP, 8'h00, 1'b0, LVL_RAND, LVL_LOW));
    settle(LVL_RAND, LVL_HIGH);
    for (int op = int'(OP_ACK) + 1; op < 8; op++)
      queue_req(tick_item(1'b1, 3'(op), 8'($urandom), 1'($urandom), LVL_RAND, LVL_RAND));
    // commands offered while a write is in flight
    queue_req(tick_item(1'b1, OP_WRITE, 8'h5A, 1'b0, LVL_RAND, LVL_HIGH));
    repeat (6)
      queue_req(tick_item(1'b1, 3'($urandom), 8'($urandom), 1'($urandom),
                          LVL_RAND, LVL_RAND));
    settle(LVL_RAND, LVL_HIGH);

    set_delay(16'd1);
    random_ticks(80);
    settle(LVL_RAND, LVL_RAND);

    steady = 1'b1;
    set_delay(16'd2);
    random_ticks(60);
    settle(LVL_RAND, LVL_RAND);
    steady = 1'b0;

    set_delay(16'd3);
    random_ticks(60);
    settle(LVL_RAND, LVL_RAND);

    set_delay(16'($urandom_range(4, 7)));
    random_ticks(50);
    settle(LVL_RAND, LVL_RAND);

    // widest delay: the engine stays in the first start phase, later commands ignored
    set_delay(16'hFFFF);
    queue_req(tick_item(1'b1, OP_START, 8'h00, 1'b0, LVL_HIGH, LVL_HIGH));
    repeat (40)
      queue_req(tick_item(1'b1, 3'($urandom), 8'($urandom), 1'($urandom),
                          LVL_RAND, LVL_RAND));

    wait_drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** i2c_master_bit_engine_core: PASSED **");
    end else begin
      $display("** i2c_master_bit_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
